/* src/rpd_pkg.sv */
// Shared types and constants for the run-length pixel decoder.
// Holds the item structs, command format between front and back, and code names.
// No dependencies.
`timescale 1ns / 1ps

package rpd_pkg;

    // Palette and command queue sizes.
    localparam int PAL_DEPTH   = 256;
    localparam int PAL_AW      = $clog2(PAL_DEPTH);
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int RUN_W       = 7;
    localparam int IDX_W       = 20;

    // Layer format words.
    localparam logic [31:0] FMT_PAL_A = 32'h040012F9;
    localparam logic [31:0] FMT_PAL_B = 32'h040012FB;
    localparam logic [31:0] FMT_RGBA  = 32'h0C0012F9;

    // Code byte fields.
    localparam logic [7:0] CODE_COUNT_MASK = 8'h3F;
    localparam logic [1:0] CODE_TRANSP     = 2'b11;

    // Request types.
    localparam logic [1:0] REQ_DATA  = 2'd0;
    localparam logic [1:0] REQ_PAL   = 2'd1;
    localparam logic [1:0] REQ_START = 2'd2;

    // Result status codes.
    localparam logic [1:0] ST_PIXEL   = 2'd0;
    localparam logic [1:0] ST_OUTSIDE = 2'd1;
    localparam logic [1:0] ST_PAST    = 2'd2;
    localparam logic [1:0] ST_UNSUP   = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] CFG_FORMAT = 2'd0;
    localparam logic [1:0] CFG_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_HEIGHT = 2'd2;
    localparam logic [1:0] CFG_IMAGE  = 2'd3;

    // Parser phase.
    typedef enum logic [1:0] {
        PH_CODE,
        PH_REPEAT,
        PH_LITERAL
    } t_phase;

    // Command kinds passed from front to back.
    typedef enum logic [1:0] {
        CMD_CLEAR,
        CMD_SKIP,
        CMD_RUN,
        CMD_STATUS
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind        kind;
        logic [RUN_W-1:0] cnt;
        logic [31:0]      color;
        logic [1:0]       status;
    } t_cmd;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [7:0]  data_byte;
        logic [7:0]  pal_index;
        logic [31:0] pal_color;
    } t_in_item;

    typedef struct packed {
        logic [IDX_W-1:0] pixel_index;
        logic [31:0]      pixel_color;
        logic             run_last;
        logic [1:0]       status;
    } t_out_item;

endpackage

/* src/rpd_front.sv */
// Front end of the decoder: accepts items, parses the byte stream, owns the palette.
// Produces commands for the back end through a one-entry holding register.
// Depends on rpd_pkg.
`timescale 1ns / 1ps

module rpd_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  rpd_pkg::t_in_item i_in_data,
    input  logic [31:0]      i_format_code,
    input  logic [31:0]      i_image_bytes,
    input  logic             i_q_full,
    output logic             o_push,
    output rpd_pkg::t_cmd    o_cmd
);
    import rpd_pkg::*;

    // Parser state.
    t_phase           r_phase, n_phase;
    logic [RUN_W-1:0] r_run, n_run;
    logic [31:0]      r_asm, n_asm;
    logic [1:0]       r_pos, n_pos;
    logic [31:0]      r_bytes, n_bytes;

    // Holding register in front of the queue.
    logic             r_pv, n_pv;
    t_cmd             r_pcmd, n_pcmd;
    logic             r_puse_pal, n_puse_pal;

    // Palette memory and its registered read port.
    logic [31:0]      r_pal [PAL_DEPTH];
    logic [31:0]      r_pal_rd;
    logic             pal_we;
    logic             pal_re;

    logic             acc;
    logic             is_pal;
    logic             is_rgba;
    logic             data_ok;
    logic             code_ok;
    logic             operand;
    logic             color_done;
    logic             run_end;
    logic [7:0]       b;
    logic [RUN_W-1:0] count;
    logic [31:0]      bytes_inc;
    logic [31:0]      asm_new;

    // Handshake: the holding register must be free or leaving this cycle.
    assign o_push     = r_pv && !i_q_full;
    assign o_in_stall = r_pv && !o_push;
    assign acc        = i_in_valid && !o_in_stall;

    // Classification of the incoming item.
    assign b          = i_in_data.data_byte;
    assign is_pal     = (i_format_code == FMT_PAL_A) || (i_format_code == FMT_PAL_B);
    assign is_rgba    = (i_format_code == FMT_RGBA);
    assign data_ok    = acc && (i_in_data.req_type == REQ_DATA) && (is_pal || is_rgba);
    assign code_ok    = data_ok && (r_phase == PH_CODE) && (r_bytes < i_image_bytes);
    assign operand    = data_ok && (r_phase != PH_CODE);
    assign color_done = operand && (is_pal || (r_pos == 2'd3));
    assign run_end    = color_done && ((r_phase == PH_REPEAT) || (r_run == RUN_W'(1)));
    assign count      = RUN_W'(b & CODE_COUNT_MASK) + RUN_W'(1);
    assign bytes_inc  = (r_bytes != '1) ? r_bytes + 32'd1 : r_bytes;
    assign asm_new    = r_asm | ({24'd0, b} << {r_pos, 3'b000});
    assign pal_we     = acc && (i_in_data.req_type == REQ_PAL);
    assign pal_re     = operand && is_pal;

    // Next phase.
    always_comb begin
        n_phase = r_phase;
        if (acc && (i_in_data.req_type == REQ_START)) begin
            n_phase = PH_CODE;
        end else if (code_ok && (b[7:6] != CODE_TRANSP)) begin
            n_phase = b[7] ? PH_REPEAT : PH_LITERAL;
        end else if (run_end) begin
            n_phase = PH_CODE;
        end
    end

    // Parser datapath and command generation.
    always_comb begin
        n_run      = r_run;
        n_asm      = r_asm;
        n_pos      = r_pos;
        n_bytes    = r_bytes;
        n_pv       = o_push ? 1'b0 : r_pv;
        n_pcmd     = r_pcmd;
        n_puse_pal = r_puse_pal;
        if (acc) begin
            unique case (i_in_data.req_type)
                REQ_START: begin
                    n_run        = '0;
                    n_asm        = '0;
                    n_pos        = '0;
                    n_bytes      = '0;
                    n_pv         = 1'b1;
                    n_pcmd       = '{kind: CMD_CLEAR, cnt: '0, color: '0, status: ST_PIXEL};
                    n_puse_pal   = 1'b0;
                end
                REQ_DATA: begin
                    if (!(is_pal || is_rgba)) begin
                        n_pv       = 1'b1;
                        n_pcmd     = '{kind: CMD_STATUS, cnt: '0, color: '0, status: ST_UNSUP};
                        n_puse_pal = 1'b0;
                    end else if (r_phase == PH_CODE) begin
                        if (!code_ok) begin
                            n_pv       = 1'b1;
                            n_pcmd     = '{kind: CMD_STATUS, cnt: '0, color: '0,
                                           status: ST_PAST};
                            n_puse_pal = 1'b0;
                        end else begin
                            n_bytes = bytes_inc;
                            n_asm   = '0;
                            n_pos   = '0;
                            if (b[7:6] == CODE_TRANSP) begin
                                n_pv       = 1'b1;
                                n_pcmd     = '{kind: CMD_SKIP, cnt: count, color: '0,
                                               status: ST_PIXEL};
                                n_puse_pal = 1'b0;
                            end else begin
                                n_run = count;
                            end
                        end
                    end else begin
                        n_bytes = bytes_inc;
                        if (!is_pal) begin
                            n_asm = asm_new;
                            n_pos = r_pos + 2'd1;
                        end
                        if (color_done) begin
                            // A palette lookup leaves any partial RGBA color in place.
                            if (!is_pal) begin
                                n_asm = '0;
                                n_pos = '0;
                            end
                            n_pv       = 1'b1;
                            n_puse_pal = is_pal;
                            n_pcmd     = '{kind: CMD_RUN, cnt: r_run, color: asm_new,
                                           status: ST_PIXEL};
                            if (r_phase == PH_REPEAT) begin
                                n_run = '0;
                            end else begin
                                n_pcmd.cnt = RUN_W'(1);
                                if (r_run != '0) begin
                                    n_run = r_run - RUN_W'(1);
                                end
                            end
                        end
                    end
                end
                default: begin
                    // Palette writes go straight to memory; request type 3 is ignored.
                end
            endcase
        end
    end

    // Command handed to the queue, with the palette colour filled in.
    always_comb begin
        o_cmd = r_pcmd;
        if (r_puse_pal) begin
            o_cmd.color = r_pal_rd;
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_CODE;
            r_run   <= '0;
            r_asm   <= '0;
            r_pos   <= '0;
            r_bytes <= '0;
            r_pv    <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_run   <= n_run;
            r_asm   <= n_asm;
            r_pos   <= n_pos;
            r_bytes <= n_bytes;
            r_pv    <= n_pv;
        end
    end

    // Holding register payload.
    always_ff @(posedge i_clk) begin
        r_pcmd     <= n_pcmd;
        r_puse_pal <= n_puse_pal;
    end

    // Palette memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (pal_we) begin
            r_pal[i_in_data.pal_index[PAL_AW-1:0]] <= i_in_data.pal_color;
        end
        if (pal_re) begin
            r_pal_rd <= r_pal[b[PAL_AW-1:0]];
        end
    end

`ifndef ASSERT_OFF
    // A started run always has pixels left to cover.
    a_run_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_CODE) |-> (r_run != '0))
        else $error("parser in a run phase with zero remaining count");

    // A palette-sourced command only comes from a run operand.
    a_pal_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pv && r_puse_pal) |-> (r_pcmd.kind == CMD_RUN))
        else $error("palette colour attached to a non-run command");
`endif

endmodule

/* src/rpd_queue.sv */
// Short command queue between the decoder front and back ends.
// Register-based with a combinational head read.
// Depends on rpd_pkg.
`timescale 1ns / 1ps

module rpd_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  rpd_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output rpd_pkg::t_cmd o_head
);
    import rpd_pkg::*;

    t_cmd                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr, n_wr;
    logic [QUEUE_AW-1:0] r_rd, n_rd;
    logic [QUEUE_AW:0]   r_count, n_count;

    assign o_full  = (r_count == (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd];

    // Pointer and occupancy update.
    always_comb begin
        n_wr    = i_push ? r_wr + QUEUE_AW'(1) : r_wr;
        n_rd    = i_pop ? r_rd + QUEUE_AW'(1) : r_rd;
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + (QUEUE_AW + 1)'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - (QUEUE_AW + 1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

`ifndef ASSERT_OFF
    // No transfer into a full queue and no removal from an empty one.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full) && !(i_pop && !o_valid))
        else $error("queue overflow or underflow");
`endif

endmodule

/* src/rpd_back.sv */
// Back end of the decoder: expands run commands into pixel results.
// Tracks the pixel offset, frame limit and the output register.
// Depends on rpd_pkg.
`timescale 1ns / 1ps

module rpd_back #(
    parameter int MAX_PIXELS = 1048576
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [15:0]        i_frame_width,
    input  logic [15:0]        i_frame_height,
    input  logic               i_q_valid,
    input  rpd_pkg::t_cmd      i_q_head,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output rpd_pkg::t_out_item o_out_data
);
    import rpd_pkg::*;

    localparam int OFFW = $clog2(MAX_PIXELS + 1);
    localparam logic [31:0]     MAX32   = 32'(MAX_PIXELS);
    localparam logic [OFFW-1:0] MAX_OFF = OFFW'(MAX_PIXELS);
    localparam logic [OFFW:0]   MAX_SUM = (OFFW + 1)'(MAX_PIXELS);

    logic [OFFW-1:0]  r_offset, n_offset;
    logic [OFFW-1:0]  r_lim;
    logic             r_act, n_act;
    logic [RUN_W-1:0] r_cnt, n_cnt;
    logic [31:0]      r_color, n_color;
    logic             r_out_valid, n_out_valid;
    t_out_item        r_out, n_out;

    logic [31:0]      area;
    logic [OFFW-1:0]  n_lim;
    logic             can_load;
    logic [OFFW:0]    skip_sum;
    logic [OFFW+IDX_W-1:0] idx_ext;

    // Frame limit, registered from the configuration.
    assign area  = {16'd0, i_frame_width} * {16'd0, i_frame_height};
    assign n_lim = (area > MAX32) ? MAX_OFF : area[OFFW-1:0];

    assign can_load = !r_out_valid || !i_out_stall;
    assign skip_sum = {1'b0, r_offset} + (OFFW + 1)'(i_q_head.cnt);
    assign idx_ext  = {{IDX_W{1'b0}}, r_offset};

    // Run expansion and command execution.
    always_comb begin
        n_offset    = r_offset;
        n_act       = r_act;
        n_cnt       = r_cnt;
        n_color     = r_color;
        n_out       = r_out;
        n_out_valid = (r_out_valid && !i_out_stall) ? 1'b0 : r_out_valid;
        o_pop       = 1'b0;
        if (r_act) begin
            if (can_load) begin
                n_out_valid      = 1'b1;
                n_out.run_last   = (r_cnt == RUN_W'(1));
                if (r_offset < r_lim) begin
                    n_out.pixel_index = idx_ext[IDX_W-1:0];
                    n_out.pixel_color = r_color;
                    n_out.status      = ST_PIXEL;
                end else begin
                    n_out.pixel_index = '0;
                    n_out.pixel_color = '0;
                    n_out.status      = ST_OUTSIDE;
                end
                if (r_offset < MAX_OFF) begin
                    n_offset = r_offset + OFFW'(1);
                end
                n_cnt = r_cnt - RUN_W'(1);
                if (r_cnt == RUN_W'(1)) begin
                    n_act = 1'b0;
                end
            end
        end else if (i_q_valid) begin
            unique case (i_q_head.kind)
                CMD_CLEAR: begin
                    n_offset = '0;
                    o_pop    = 1'b1;
                end
                CMD_SKIP: begin
                    n_offset = (skip_sum > MAX_SUM) ? MAX_OFF : skip_sum[OFFW-1:0];
                    o_pop    = 1'b1;
                end
                CMD_RUN: begin
                    n_act   = 1'b1;
                    n_cnt   = i_q_head.cnt;
                    n_color = i_q_head.color;
                    o_pop   = 1'b1;
                end
                CMD_STATUS: begin
                    if (can_load) begin
                        n_out_valid = 1'b1;
                        n_out       = '{pixel_index: '0, pixel_color: '0, run_last: 1'b1,
                                        status: i_q_head.status};
                        o_pop       = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset    <= '0;
            r_act       <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_offset    <= n_offset;
            r_act       <= n_act;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_color <= n_color;
        r_out   <= n_out;
        r_lim   <= n_lim;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef ASSERT_OFF
    // An active run always has pixels left.
    a_act_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_act |-> (r_cnt != '0))
        else $error("active run with zero count");

    // The pixel offset never passes its saturation point.
    a_off_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_offset <= MAX_OFF)
        else $error("pixel offset above maximum");

    // Non-pixel results carry a zero colour.
    a_zero_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.status != ST_PIXEL)) |-> (r_out.pixel_color == '0))
        else $error("flagged result with nonzero colour");
`endif

endmodule

/* src/rle_pixel_decoder_unit.sv */
// Run-length pixel decoder, top level: configuration registers and the
// front end, command queue and back end. Depends on rpd_pkg, rpd_front,
// rpd_queue and rpd_back.
//
// Usage: the input channel (i_in_valid / o_in_stall / i_in_data) takes data
// bytes, palette writes and layer starts; the output channel
// (o_out_valid / i_out_stall / o_out_data) delivers pixel writes and flagged
// results. A transfer happens on a rising edge with valid high and stall low.
// The user writes configuration through i_cfg_valid / o_cfg_ready only
// while idle; the block does not enforce this. The port is always ready.
// A status result passes the front holding register, the command queue and
// the back-end output register; a run also passes the back-end run state,
// which loads its command and then sends one pixel per cycle from its
// output register while the receiver does not stall; the front keeps
// taking bytes until the four-entry command queue fills.
// Reset clears parse state, offsets, counters and the configuration; the
// palette holds undefined values until written. When the receiver stalls,
// the result holds and the back end, then the queue, then the input, stall.
`timescale 1ns / 1ps

module rle_pixel_decoder_unit #(
    parameter int MAX_PIXELS = 1048576
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  rpd_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output rpd_pkg::t_out_item o_out_data,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);
    import rpd_pkg::*;

    logic [31:0] r_format_code;
    logic [15:0] r_frame_width;
    logic [15:0] r_frame_height;
    logic [31:0] r_image_bytes;

    logic        push;
    logic        q_full;
    logic        pop;
    logic        q_valid;
    t_cmd        push_cmd;
    t_cmd        q_head;

    assign o_cfg_ready = 1'b1;

    // Configuration register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_format_code  <= '0;
            r_frame_width  <= '0;
            r_frame_height <= '0;
            r_image_bytes  <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_FORMAT: r_format_code  <= i_cfg_data;
                CFG_WIDTH:  r_frame_width  <= i_cfg_data[15:0];
                CFG_HEIGHT: r_frame_height <= i_cfg_data[15:0];
                CFG_IMAGE:  r_image_bytes  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Parser and palette.
    rpd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_in_data     (i_in_data),
        .i_format_code (r_format_code),
        .i_image_bytes (r_image_bytes),
        .i_q_full      (q_full),
        .o_push        (push),
        .o_cmd         (push_cmd)
    );

    // Command queue.
    rpd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_head  (q_head)
    );

    // Run expansion and result output.
    rpd_back #(
        .MAX_PIXELS (MAX_PIXELS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_frame_width  (r_frame_width),
        .i_frame_height (r_frame_height),
        .i_q_valid      (q_valid),
        .i_q_head       (q_head),
        .o_pop          (pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_data     (o_out_data)
    );

endmodule
